/* rtl/swfa_pkg.sv */
// ----------------------------------------------------------------------------
// swfa_pkg: shared types and constants of the shutter-weighted accumulator
// Field widths, register indexes, command codes and divider status.
// ----------------------------------------------------------------------------
package swfa_pkg;

  localparam int STEP_WIDTH   = 20;
  localparam int EXP_WIDTH    = 17;
  localparam int WEIGHT_WIDTH = 17;
  localparam int KIND_WIDTH   = 2;
  localparam int CFG_WIDTH    = 20;
  localparam int REP_WIDTH    = 3;

  localparam logic REG_PHASE_STEP = 1'b0;
  localparam logic REG_EXPOSURE   = 1'b1;

  typedef enum logic [KIND_WIDTH-1:0] {
    KIND_ACC    = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_REPEAT = 2'd2
  } kind_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/swfa_div.sv */
// ----------------------------------------------------------------------------
// swfa_div: restoring divider for the accumulation weight
// Forms (dividend << (WIDTH-1)) / divisor, one quotient bit per cycle,
// for dividend <= divisor. The quotient holds until the next start.
// ----------------------------------------------------------------------------
module swfa_div #(
  parameter int WIDTH = 17
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [WIDTH-1:0]        dividend,
  input  logic [WIDTH-1:0]        divisor,
  output logic [WIDTH-1:0]        quotient,
  output swfa_pkg::div_stat_t     stat
);
  import swfa_pkg::*;

  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH:0]   rem;
  logic [WIDTH:0]   rem_sub;
  logic             bit_q;
  logic [CW-1:0]    cnt;

  // trial subtract
  always_comb begin
    bit_q   = (rem >= {1'b0, divisor});
    rem_sub = bit_q ? (rem - {1'b0, divisor}) : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else if (start) begin
      stat.busy <= 1'b1;
      stat.done <= 1'b0;
      cnt       <= CW'(WIDTH);
    end else if (stat.busy) begin
      cnt <= cnt - CW'(1);
      if (cnt == CW'(1)) begin
        stat.busy <= 1'b0;
        stat.done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= {1'b0, dividend};
      quotient <= '0;
    end else if (stat.busy) begin
      rem      <= {rem_sub[WIDTH-1:0], 1'b0};
      quotient <= {quotient[WIDTH-2:0], bit_q};
    end
  end

endmodule

/* rtl/shutter_weighted_frame_accumulation.sv */
// ----------------------------------------------------------------------------
// shutter_weighted_frame_accumulation: motion-blur sub-frame scheduler
// Phase accumulator over output periods; emits weighted accumulate,
// finished-frame and repeated-frame commands for each sub-frame tick.
// ----------------------------------------------------------------------------
//  channel | signals                                       | role
//  --------+-----------------------------------------------+------------------
//  tick    | tick_valid, tick_ready, sub_frame_tick        | sub-frame in
//  cmd     | cmd_valid, cmd_ready, command_kind, weight,   | command out
//          | last_of_run                                   |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data     | register writes
//
//  Each weighted accumulate of a tick takes one pass of the shared
//  bit-serial divider; the other commands need no divider pass.
//  The block takes one tick at a time; tick_ready is high only when idle.
//  Reset: synchronous, clears phase, registers to their defaults, and the
//  output valid. A stalled cmd transfer holds the sequencer in place.
// ----------------------------------------------------------------------------
module shutter_weighted_frame_accumulation #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              tick_valid,
  output logic                              tick_ready,
  input  logic                              sub_frame_tick,
  output logic                              cmd_valid,
  input  logic                              cmd_ready,
  output logic [swfa_pkg::KIND_WIDTH-1:0]   command_kind,
  output logic [swfa_pkg::WEIGHT_WIDTH-1:0] weight,
  output logic                              last_of_run,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [swfa_pkg::CFG_WIDTH-1:0]    cfg_data
);
  import swfa_pkg::*;

  // Phase is a pure fraction; a step reaches 8.0; weights reach 1.0.
  localparam int PW      = FRAC_BITS;
  localparam int SW      = FRAC_BITS + 4;
  localparam int QW      = FRAC_BITS + 1;
  localparam int STEP_CW = (SW > STEP_WIDTH) ? SW : STEP_WIDTH;
  localparam int EXP_CW  = (QW > EXP_WIDTH) ? QW : EXP_WIDTH;

  localparam logic [STEP_CW-1:0] STEP_MAX = STEP_CW'(8) << FRAC_BITS;
  localparam logic [EXP_CW-1:0]  EXP_ONE  = EXP_CW'(1) << FRAC_BITS;
  localparam logic [QW-1:0]      ONE_Q    = QW'(1) << FRAC_BITS;
  localparam logic [SW-1:0]      ONE_S    = SW'(1) << FRAC_BITS;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EVAL   = 6'b000010,
    S_DSTART = 6'b000100,
    S_DWAIT  = 6'b001000,
    S_FRAME  = 6'b010000,
    S_REPEAT = 6'b100000
  } state_t;

  state_t                 state, state_next;
  logic [STEP_WIDTH-1:0]  phase_step;
  logic [EXP_WIDTH-1:0]   exposure;
  logic [PW-1:0]          phase;
  logic [QW-1:0]          e_r;
  logic [QW-1:0]          win;
  logic [SW-1:0]          p_r;
  logic [QW-1:0]          covered;
  logic                   closing;
  logic                   lead;
  logic [REP_WIDTH-1:0]   rep_cnt;
  kind_t                  kind_q;

  logic [STEP_CW-1:0]     step_x;
  logic [SW-1:0]          step_eff;
  logic [EXP_CW-1:0]      exp_x;
  logic [EXP_CW-1:0]      exp_eff;
  logic [QW-1:0]          lo;
  logic [SW-1:0]          p_wrap;
  logic                   tick_go;
  logic                   out_free;
  logic                   emit;
  logic                   div_start;
  logic [QW-1:0]          quotient;
  div_stat_t              div_stat;

  assign tick_ready = (state == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign tick_go    = tick_valid && tick_ready && sub_frame_tick;
  assign out_free   = !cmd_valid || cmd_ready;
  assign div_start  = (state == S_DSTART);
  assign command_kind = kind_q;

  // Load a new command into the output register this cycle.
  assign emit = out_free && (((state == S_DWAIT) && div_stat.done) ||
                             (state == S_FRAME) || (state == S_REPEAT));

  // Saturate step to 8.0 and exposure to the range 1 .. 1.0.
  always_comb begin
    step_x   = STEP_CW'(phase_step);
    step_eff = SW'((step_x > STEP_MAX) ? STEP_MAX : step_x);
    exp_x    = EXP_CW'(exposure);
    if (exp_x == '0) begin
      exp_eff = EXP_CW'(1);
    end else if (exp_x > EXP_ONE) begin
      exp_eff = EXP_ONE;
    end else begin
      exp_eff = exp_x;
    end
    lo     = ({1'b0, phase} > win) ? {1'b0, phase} : win;
    p_wrap = p_r - ONE_S;
  end

  // Sequencer: evaluate, run the divider, then emit the command run.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (tick_go) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        if (p_r <= SW'(win)) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_DSTART;
        end
      end
      S_DSTART: state_next = S_DWAIT;
      S_DWAIT: begin
        if (div_stat.done && out_free) begin
          state_next = closing ? S_FRAME : S_IDLE;
        end
      end
      S_FRAME: begin
        if (out_free) begin
          if (rep_cnt != '0) begin
            state_next = S_REPEAT;
          end else if (lead) begin
            state_next = S_DSTART;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_REPEAT: begin
        if (out_free && rep_cnt == REP_WIDTH'(1)) begin
          state_next = lead ? S_DSTART : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      phase_step <= STEP_WIDTH'(65536);
      exposure   <= EXP_WIDTH'(32768);
      phase      <= '0;
      cmd_valid  <= 1'b0;
      closing    <= 1'b0;
      lead       <= 1'b0;
      rep_cnt    <= '0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PHASE_STEP: phase_step <= cfg_data[STEP_WIDTH-1:0];
          REG_EXPOSURE:   exposure   <= cfg_data[EXP_WIDTH-1:0];
          default: ;
        endcase
      end

      // Drop valid after a transfer unless the next command replaces it
      if (cmd_valid && cmd_ready && !emit) begin
        cmd_valid <= 1'b0;
      end

      case (state)
        S_EVAL: begin
          if (p_r <= SW'(win)) begin
            phase <= p_r[PW-1:0];
          end else if (p_r < ONE_S) begin
            // inside the window, period still open
            phase   <= p_r[PW-1:0];
            covered <= QW'(p_r) - lo;
            closing <= 1'b0;
            lead    <= 1'b0;
            rep_cnt <= '0;
          end else begin
            // period closes: wrap, count skipped periods
            phase   <= p_wrap[PW-1:0];
            covered <= ONE_Q - lo;
            closing <= 1'b1;
            rep_cnt <= p_wrap[FRAC_BITS+REP_WIDTH-1:FRAC_BITS];
            lead    <= ({1'b0, p_wrap[PW-1:0]} > win);
          end
        end
        S_DWAIT: begin
          if (div_stat.done && out_free) begin
            cmd_valid   <= 1'b1;
            kind_q      <= KIND_ACC;
            weight      <= WEIGHT_WIDTH'(quotient);
            last_of_run <= !closing;
          end
        end
        S_FRAME: begin
          if (out_free) begin
            cmd_valid   <= 1'b1;
            kind_q      <= KIND_DONE;
            weight      <= '0;
            last_of_run <= (rep_cnt == '0) && !lead;
            closing     <= 1'b0;
            covered     <= {1'b0, phase} - win;
          end
        end
        S_REPEAT: begin
          if (out_free) begin
            cmd_valid   <= 1'b1;
            kind_q      <= KIND_REPEAT;
            weight      <= '0;
            last_of_run <= (rep_cnt == REP_WIDTH'(1)) && !lead;
            rep_cnt     <= rep_cnt - REP_WIDTH'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Latch the tick's operands: effective exposure, window start, new phase.
  always_ff @(posedge clk) begin
    if (tick_go) begin
      e_r <= QW'(exp_eff);
      win <= ONE_Q - QW'(exp_eff);
      p_r <= SW'(phase) + step_eff;
    end
  end

  swfa_div #(
    .WIDTH (QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (covered),
    .divisor  (e_r),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // Divider is never left running while the block takes a new tick.
  a_idle_div: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !div_stat.busy)
    else $error("divider busy while idle");

  // A repeat is only issued with skipped periods left to report.
  a_rep_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_REPEAT) |-> (rep_cnt != '0))
    else $error("repeat state with empty count");

  // Weight never exceeds one output period share.
  a_quot_max: assert property (@(posedge clk) disable iff (rst)
    (state == S_DWAIT && div_stat.done) |-> (quotient <= ONE_Q))
    else $error("weight above 1.0");

  // Frame commands carry no weight.
  a_zero_weight: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && kind_q != KIND_ACC) |-> (weight == '0))
    else $error("weight on frame command");

  // Each divider pass starts as the sequencer moves into the wait state.
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_DSTART) |=> (state == S_DWAIT && div_stat.busy))
    else $error("divider did not start");

endmodule

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the shutter-weighted frame accumulator
// Drives sub-frame ticks and register writes, keeps its own Q16 phase
// accumulator to work out the command stream each tick should cause, and
// compares every command transfer with the oldest outstanding command.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swfa_pkg::*;

  localparam int FRAC = 16;
  localparam bit [39:0] ONE_Q = 40'd1 << FRAC;
  localparam bit [39:0] STEP_CAP = ONE_Q * 8;
  // Allow margin after a drain before touching registers.
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    kind_t             kind;
    logic [16:0]       weight;
    logic              last;
  } frame_cmd_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    tick_valid = 1'b0;
  logic                    tick_ready;
  logic                    sub_frame_tick = 1'b0;
  logic                    cmd_valid;
  logic                    cmd_ready = 1'b0;
  logic [KIND_WIDTH-1:0]   command_kind;
  logic [WEIGHT_WIDTH-1:0] weight;
  logic                    last_of_run;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic                    cfg_index = 1'b0;
  logic [CFG_WIDTH-1:0]    cfg_data = '0;

  // Shadow copy of the block's registers and phase
  bit [19:0] step_reg;
  bit [16:0] exposure_reg;
  bit [19:0] phase_q;

  frame_cmd_t cmd_expect[$];
  frame_cmd_t want;
  int         errors = 0;

  // Receiver behaviour: a stall pattern plus an optional long hold-off
  int         rx_mode = 0;
  int         hold_left = 0;
  int         rx_count = 0;

  shutter_weighted_frame_accumulation uut (
    .clk            (clk),
    .rst            (rst),
    .tick_valid     (tick_valid),
    .tick_ready     (tick_ready),
    .sub_frame_tick (sub_frame_tick),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .command_kind   (command_kind),
    .weight         (weight),
    .last_of_run    (last_of_run),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Phase accumulator: work out the commands caused by one accepted tick and
  // queue them, flagging the final one of the run.
  // --------------------------------------------------------------------------
  function automatic void advance_phase();
    bit [39:0]   e, st, win, p, lo, share;
    kind_t       kinds [10];
    bit [16:0]   weights [10];
    int          n, reps;
    frame_cmd_t  c;
    n = 0;
    // Clamp exposure into (0, 1.0] and the step to at most 8.0
    e = 40'(exposure_reg);
    if (e == 0) e = 40'd1;
    if (e > ONE_Q) e = ONE_Q;
    st = (40'(step_reg) > STEP_CAP) ? STEP_CAP : 40'(step_reg);
    win = ONE_Q - e;
    p = 40'(phase_q) + st;
    lo = (40'(phase_q) > win) ? 40'(phase_q) : win;
    // Still before the shutter opens: advance silently
    if (p <= win) begin
      phase_q = p[19:0];
      return;
    end
    if (p < ONE_Q) begin
      phase_q = p[19:0];
      share = ((p - lo) << FRAC) / e;
      kinds[n] = KIND_ACC;
      weights[n] = share[16:0];
      n++;
    end else begin
      // Close the old period, emit the frame, then repeats for skipped periods
      share = ((ONE_Q - lo) << FRAC) / e;
      kinds[n] = KIND_ACC;
      weights[n] = share[16:0];
      n++;
      kinds[n] = KIND_DONE;
      weights[n] = '0;
      n++;
      p = p - ONE_Q;
      reps = int'(p >> FRAC);
      for (int i = 0; i < reps; i++) begin
        kinds[n] = KIND_REPEAT;
        weights[n] = '0;
        n++;
      end
      p = p & (ONE_Q - 1);
      phase_q = p[19:0];
      // Leading accumulate only strictly inside the new window
      if (p > 0 && p > win) begin
        share = ((p - win) << FRAC) / e;
        kinds[n] = KIND_ACC;
        weights[n] = share[16:0];
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      c.kind = kinds[i];
      c.weight = weights[i];
      c.last = (i == n - 1);
      cmd_expect.push_back(c);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Command checker: sample each transfer at the rising edge, compare against
  // the oldest outstanding command.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && cmd_valid && cmd_ready) begin
      if (cmd_expect.size() == 0) begin
        $display("%0t: unexpected command kind %0d weight %0d last %0d",
                 $time, command_kind, weight, last_of_run);
        errors++;
      end else begin
        want = cmd_expect.pop_front();
        if (command_kind !== want.kind) begin
          $display("%0t: command_kind expected %0d actual %0d",
                   $time, want.kind, command_kind);
          errors++;
        end
        if (weight !== want.weight) begin
          $display("%0t: weight expected %0d actual %0d", $time, want.weight, weight);
          errors++;
        end
        if (last_of_run !== want.last) begin
          $display("%0t: last_of_run expected %0d actual %0d",
                   $time, want.last, last_of_run);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: a long hold-off takes priority, otherwise stall per rx_mode.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    rx_count++;
    if (hold_left > 0) begin
      cmd_ready <= 1'b0;
      hold_left--;
    end else begin
      case (rx_mode)
        0: cmd_ready <= 1'b1;
        1: cmd_ready <= ($urandom_range(99) < 60);
        2: cmd_ready <= !((rx_count % 7 == 0) || (rx_count % 7 == 3));
        default: cmd_ready <= ($urandom_range(99) < 25);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake helpers
  // --------------------------------------------------------------------------
  // Offer one tick and hold it until transferred; valid is left high so the
  // caller decides whether the next item follows back to back.
  task automatic send_tick(input logic t);
    @(negedge clk);
    tick_valid <= 1'b1;
    sub_frame_tick <= t;
    do @(posedge clk); while (!tick_ready);
    if (t) advance_phase();
  endtask

  task automatic tick_idle(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      tick_valid <= 1'b0;
    end
  endtask

  // Drop valid and wait for every outstanding command to arrive
  task automatic drain();
    @(negedge clk);
    tick_valid <= 1'b0;
    while (cmd_expect.size() != 0) @(posedge clk);
  endtask

  // Drain, then let a tick with no command finish before touching registers
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_WIDTH-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_PHASE_STEP) step_reg = data;
    else exposure_reg = data[16:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Send ticks in bursts of random length with random gaps; only real ticks
  // count towards the total, empty ones are mixed in at (100 - tick_pct)%.
  task automatic send_run(input int count, input int tick_pct,
                          input int max_burst, input int max_gap);
    int sent, burst;
    logic t;
    sent = 0;
    burst = $urandom_range(1, max_burst);
    while (sent < count) begin
      t = ($urandom_range(99) < tick_pct);
      send_tick(t);
      if (t) sent++;
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, max_burst);
        if (max_gap > 0) tick_idle($urandom_range(1, max_gap));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset values: step 1.0, exposure 0.5, so each real tick closes a full frame
  task automatic test_defaults();
    rx_mode = 0;
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    settle();
  endtask

  // Land exactly on 1.0 (no leading accumulate), then exactly on the window
  // edge (no accumulate at all), then close a frame from the edge.
  task automatic test_window_edges();
    rx_mode = 1;
    cfg_write(REG_PHASE_STEP, (phase_q == 0) ? 20'h10000 : 20'h10000 - phase_q);
    send_tick(1'b1);
    settle();
    cfg_write(REG_PHASE_STEP, 20'h08000);
    cfg_write(REG_EXPOSURE, 20'h08000);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();
  endtask

  // Zero step inside the window, saturated and maximal steps, smallest step
  task automatic test_step_extremes();
    rx_mode = 2;
    cfg_write(REG_PHASE_STEP, 20'h0C000);
    send_tick(1'b1);
    settle();
    cfg_write(REG_PHASE_STEP, 20'h00000);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();
    // Above 8.0: saturates, giving the longest run of commands
    cfg_write(REG_PHASE_STEP, 20'hFFFFF);
    send_tick(1'b1);
    settle();
    cfg_write(REG_PHASE_STEP, 20'h80000);
    send_tick(1'b1);
    settle();
    cfg_write(REG_PHASE_STEP, 20'h00001);
    send_tick(1'b1);
    send_tick(1'b1);
    settle();
  endtask

  // Zero exposure (treated as 1), oversized exposure (saturates), full and
  // minimal shutter
  task automatic test_exposure_extremes();
    rx_mode = 1;
    cfg_write(REG_PHASE_STEP, 20'h04000);
    cfg_write(REG_EXPOSURE, 20'h00000);
    repeat (4) send_tick(1'b1);
    settle();
    cfg_write(REG_EXPOSURE, 20'h1FFFF);
    repeat (3) send_tick(1'b1);
    settle();
    cfg_write(REG_PHASE_STEP, 20'h00001);
    cfg_write(REG_EXPOSURE, 20'h10000);
    repeat (2) send_tick(1'b1);
    settle();
    cfg_write(REG_EXPOSURE, 20'h00001);
    send_tick(1'b1);
    settle();
  endtask

  // Hold the command side off while ticks keep coming, so the block backs up
  // and stalls its input; then pause until everything has drained.
  task automatic test_backpressure();
    rx_mode = 0;
    cfg_write(REG_PHASE_STEP, 20'h2C000);
    cfg_write(REG_EXPOSURE, 20'h0C000);
    hold_left = 300;
    send_run(20, 100, 20, 0);
    settle();
  endtask

  // Random settings per phase, random traffic shape, pause mid-phase
  task automatic test_random_traffic();
    logic [CFG_WIDTH-1:0] step_val, exp_val;
    int gap;
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(5))
        0: step_val = CFG_WIDTH'($urandom_range(1, 16'hFFFF));
        1: step_val = 20'h10000 - 20'h80 + CFG_WIDTH'($urandom_range(0, 16'h100));
        2: step_val = CFG_WIDTH'($urandom_range(1, 20'h80000));
        3: step_val = CFG_WIDTH'($urandom_range(20'h80001, 20'hFFFFF));
        4: step_val = CFG_WIDTH'($urandom_range(1, 16'h0800));
        default: step_val = CFG_WIDTH'($urandom());
      endcase
      if ($urandom_range(15) == 0) step_val = '0;
      case ($urandom_range(4))
        0: exp_val = CFG_WIDTH'($urandom_range(1, 20'h10000));
        1: exp_val = CFG_WIDTH'($urandom_range(1, 16'h0400));
        2: exp_val = CFG_WIDTH'($urandom_range(16'hF000, 20'h10000));
        3: exp_val = CFG_WIDTH'($urandom());
        default: exp_val = '0;
      endcase
      // Alternate the write order between phases
      if (ph % 2 == 0) begin
        cfg_write(REG_PHASE_STEP, step_val);
        cfg_write(REG_EXPOSURE, exp_val);
      end else begin
        cfg_write(REG_EXPOSURE, exp_val);
        cfg_write(REG_PHASE_STEP, step_val);
      end
      rx_mode = $urandom_range(3);
      gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 8);
      send_run(21, 90, 16, gap);
      drain();
      rx_mode = $urandom_range(3);
      send_run(26, 90, 16, gap);
      settle();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    step_reg = 20'h10000;
    exposure_reg = 17'h08000;
    phase_q = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_defaults();
    test_window_edges();
    test_step_extremes();
    test_exposure_extremes();
    test_backpressure();
    test_random_traffic();
    settle();
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/swfa_pkg.sv
rtl/swfa_div.sv
rtl/shutter_weighted_frame_accumulation.sv
sim/tb.sv
